// ===== rtl/pse_pkg.sv =====
// types, constants and character class functions for the printable string extractor
// no dependencies; imported by the top level, the port checker and the testbench
package pse_pkg;

  typedef enum logic {
    PSE_IDLE,
    PSE_EMIT
  } pse_state_e;

  localparam logic [6:0] CHAR_DOT   = 7'h2E;
  localparam logic [6:0] CHAR_SPACE = 7'h20;
  localparam logic [6:0] CHAR_DEL   = 7'h7F;
  localparam logic [5:0] MIN_LENGTH_RESET = 6'd7;

  // letters and digits
  function automatic logic is_alnum(input logic [7:0] b);
    return (b inside {[8'h30:8'h39], [8'h41:8'h5A], [8'h61:8'h7A]});
  endfunction

  // punctuation that counts against a run: network punctuation excluded
  function automatic logic is_counted_punct(input logic [7:0] b);
    logic punct;
    logic net;
    punct = (b inside {[8'h21:8'h2F], [8'h3A:8'h40], [8'h5B:8'h60], [8'h7B:8'h7E]});
    net   = (b inside {8'h2F, 8'h3D, 8'h5B, 8'h5D, 8'h5C, 8'h28, 8'h29,
                       8'h7B, 8'h7D, 8'h3A, 8'h3C, 8'h3E, 8'h3B, 8'h20});
    return punct && !net;
  endfunction

endpackage

// ===== rtl/pse_ram.sv =====
// generic single-write, single-read synchronous ram with registered read data
// no dependencies; holds the bytes of the run being collected
module pse_ram #(
  parameter int WIDTH = 7,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/printable_string_extractor.sv =====
// printable string extractor: collects text runs in a ram and emits accepted ones cleaned
// depends on pse_pkg and pse_ram
// throughput: one payload word per cycle while collecting; input stalls while a run is emitted
// emission: characters are read one per cycle, while the sink accepts them, from the single
//   read port of the run ram via a pending slot; input resumes once the last one is registered
// reset: asynchronous, active low; clears run counters, state and min_length (to 7)
// the run ram is not cleared: only entries written in the current run are read
module printable_string_extractor
  import pse_pkg::*;
#(
  parameter int MAX_RUN = 64
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [5:0] cfg_wdata_i,    // min_length
  input  logic       s_axis_tvalid_i,
  output logic       s_axis_tready_o,
  input  logic [7:0] s_axis_tdata_i, // [7:0] data_byte
  input  logic       s_axis_tlast_i, // end_of_buffer
  output logic       m_axis_tvalid_o,
  input  logic       m_axis_tready_i,
  output logic [7:0] m_axis_tdata_o, // [6:0] out_char, [7] zero
  output logic       m_axis_tlast_o  // string_end
);

  localparam int LEN_W  = $clog2(MAX_RUN + 1);
  localparam int ADDR_W = $clog2(MAX_RUN);
  localparam int CMP_W  = LEN_W + 6;
  localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_RUN);

  pse_state_e state_q, state_d;

  logic [5:0]       min_len_q;
  logic [LEN_W-1:0] run_len_q, run_len_d;
  logic [LEN_W-1:0] alnum_q, alnum_d;
  logic [LEN_W-1:0] punct_q, punct_d;
  logic             in_run_q, in_run_d;

  logic [LEN_W-1:0] emit_len_q, emit_len_d;
  logic [LEN_W-1:0] rd_idx_q, rd_idx_d;
  logic             rdv_q, rdv_d;
  logic [6:0]       pend_q, pend_d;
  logic             pend_valid_q, pend_valid_d;
  logic [6:0]       out_char_q, out_char_d;
  logic             out_last_q, out_last_d;
  logic             out_valid_q, out_valid_d;

  logic             in_acc, run_byte, starts, take, brk, fin, pass;
  logic [LEN_W-1:0] len_inc, len_j, alnum_j, punct_j, p_j;
  logic [6:0]       wr_char, rd_char;
  logic             more, out_free, skip, consume, issue, flush;

  // input side
  assign in_acc   = s_axis_tvalid_i && s_axis_tready_o;
  assign run_byte = (s_axis_tdata_i != 8'h00) && !s_axis_tdata_i[7]
                    && (s_axis_tdata_i[6:0] != CHAR_DEL);
  assign starts   = run_byte && (s_axis_tdata_i[6:0] >= CHAR_SPACE);
  assign take     = in_acc && run_byte && (in_run_q || starts);
  assign brk      = in_acc && in_run_q && !run_byte;
  assign len_inc  = run_len_q + LEN_W'(1);
  assign fin      = brk || (take && ((len_inc == MAX_LEN) || s_axis_tlast_i));

  assign len_j   = take ? len_inc : run_len_q;
  assign alnum_j = (take && is_alnum(s_axis_tdata_i)) ? alnum_q + LEN_W'(1) : alnum_q;
  assign punct_j = (take && is_counted_punct(s_axis_tdata_i)) ? punct_q + LEN_W'(1) : punct_q;
  assign p_j     = (punct_j == '0) ? LEN_W'(1) : punct_j;

  // len / p > 3 is the same as len >= 4p
  assign pass = (CMP_W'(len_j) > CMP_W'(min_len_q))
                && (alnum_j > p_j)
                && (CMP_W'(len_j) >= (CMP_W'(p_j) << 2));

  // control bytes are stored already turned into dots
  assign wr_char = (s_axis_tdata_i[6:0] < CHAR_SPACE) ? CHAR_DOT : s_axis_tdata_i[6:0];

  always_comb begin
    run_len_d = run_len_q;
    alnum_d   = alnum_q;
    punct_d   = punct_q;
    in_run_d  = in_run_q;
    if (fin) begin
      run_len_d = '0;
      alnum_d   = '0;
      punct_d   = '0;
      in_run_d  = 1'b0;
    end else if (take) begin
      run_len_d = len_j;
      alnum_d   = alnum_j;
      punct_d   = punct_j;
      in_run_d  = 1'b1;
    end
  end

  // emission side
  assign more     = rd_idx_q < emit_len_q;
  assign out_free = !out_valid_q || m_axis_tready_i;
  assign skip     = pend_valid_q && (pend_q == CHAR_DOT) && (rd_char == CHAR_DOT);
  assign consume  = rdv_q && (skip || !pend_valid_q || out_free);
  assign issue    = (state_q == PSE_EMIT) && more && (!rdv_q || consume);
  assign flush    = (state_q == PSE_EMIT) && !more && !rdv_q && out_free;

  pse_ram #(
    .WIDTH(7),
    .DEPTH(MAX_RUN)
  ) u_run_ram (
    .clk_i  (clk_i),
    .we_i   (take),
    .waddr_i(run_len_q[ADDR_W-1:0]),
    .wdata_i(wr_char),
    .re_i   (issue),
    .raddr_i(rd_idx_q[ADDR_W-1:0]),
    .rdata_o(rd_char)
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      PSE_IDLE: begin
        if (fin && pass) begin
          state_d = PSE_EMIT;
        end
      end
      PSE_EMIT: begin
        if (flush) begin
          state_d = PSE_IDLE;
        end
      end
      default: state_d = PSE_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    s_axis_tready_o = (state_q == PSE_IDLE);
    emit_len_d   = emit_len_q;
    rd_idx_d     = rd_idx_q;
    rdv_d        = rdv_q;
    pend_d       = pend_q;
    pend_valid_d = pend_valid_q;
    out_char_d   = out_char_q;
    out_last_d   = out_last_q;
    out_valid_d  = out_valid_q && !m_axis_tready_i;

    if (fin && pass) begin
      emit_len_d   = len_j;
      rd_idx_d     = '0;
      pend_valid_d = 1'b0;
    end
    if (issue) begin
      rd_idx_d = rd_idx_q + LEN_W'(1);
      rdv_d    = 1'b1;
    end else if (consume) begin
      rdv_d = 1'b0;
    end
    // a character leaves the pending slot once the next kept one is known
    if (consume && !skip) begin
      if (pend_valid_q) begin
        out_char_d  = pend_q;
        out_last_d  = 1'b0;
        out_valid_d = 1'b1;
      end
      pend_d       = rd_char;
      pend_valid_d = 1'b1;
    end
    if (flush) begin
      out_char_d   = pend_q;
      out_last_d   = 1'b1;
      out_valid_d  = 1'b1;
      pend_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= PSE_IDLE;
      min_len_q    <= MIN_LENGTH_RESET;
      run_len_q    <= '0;
      alnum_q      <= '0;
      punct_q      <= '0;
      in_run_q     <= 1'b0;
      emit_len_q   <= '0;
      rd_idx_q     <= '0;
      rdv_q        <= 1'b0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      if (cfg_we_i) begin
        min_len_q <= cfg_wdata_i;
      end
      run_len_q    <= run_len_d;
      alnum_q      <= alnum_d;
      punct_q      <= punct_d;
      in_run_q     <= in_run_d;
      emit_len_q   <= emit_len_d;
      rd_idx_q     <= rd_idx_d;
      rdv_q        <= rdv_d;
      pend_valid_q <= pend_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_q     <= pend_d;
    out_char_q <= out_char_d;
    out_last_q <= out_last_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {1'b0, out_char_q};
  assign m_axis_tlast_o  = out_last_q;

endmodule

// ===== rtl/pse_checker.sv =====
// port checker for the printable string extractor, bound to the top level
// depends on pse_pkg
module pse_checker
  import pse_pkg::*;
(
  input logic       clk_i,
  input logic       rst_ni,
  input logic       m_axis_tvalid_o,
  input logic       m_axis_tready_i,
  input logic [7:0] m_axis_tdata_o,
  input logic       m_axis_tlast_o
);

  logic out_acc;
  logic prev_dot_q;

  assign out_acc = m_axis_tvalid_o && m_axis_tready_i;

  // last word taken was a dot inside a string
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_dot_q <= 1'b0;
    end else if (out_acc) begin
      prev_dot_q <= (m_axis_tdata_o[6:0] == CHAR_DOT) && !m_axis_tlast_o;
    end
  end

  // output register is cleared by the reset edge itself, so check it in the following cycle
  a_reset_quiet: assert property (@(posedge clk_i) !rst_ni |=> !m_axis_tvalid_o)
    else $error("output word valid during reset");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tready_i) |=>
      (m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tlast_o)))
    else $error("stalled output word changed");

  a_char_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (!m_axis_tdata_o[7] && (m_axis_tdata_o[6:0] >= CHAR_SPACE)
                         && (m_axis_tdata_o[6:0] != CHAR_DEL)))
    else $error("output character not printable");

  a_no_double_dot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_acc && prev_dot_q) |-> (m_axis_tdata_o[6:0] != CHAR_DOT))
    else $error("adjacent dots not collapsed");

endmodule

bind printable_string_extractor pse_checker u_pse_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .m_axis_tvalid_o(m_axis_tvalid_o),
  .m_axis_tready_i(m_axis_tready_i),
  .m_axis_tdata_o (m_axis_tdata_o),
  .m_axis_tlast_o (m_axis_tlast_o)
);

// ===== test/testbench.sv =====
// self-checking testbench for printable_string_extractor: payload words go in on the
// slave stream, cleaned strings are checked against an in-bench model of the run logic
// depends on pse_pkg and the block's rtl
module testbench;
  import pse_pkg::*;

  localparam int          TEXT_MAX      = 64;
  localparam int unsigned SETTLE_CYCLES = 100;
  localparam int unsigned LONG_HOLD     = 300;
  localparam int unsigned TIMEOUT       = 5_000_000;

  logic       clk_i           = 1'b0;
  logic       rst_ni          = 1'b0;
  logic       cfg_we_i        = 1'b0;
  logic [5:0] cfg_wdata_i     = '0;
  logic       s_axis_tvalid_i = 1'b0;
  logic       s_axis_tready_o;
  logic [7:0] s_axis_tdata_i  = '0;  // [7:0] data_byte
  logic       s_axis_tlast_i  = 1'b0; // end_of_buffer
  logic       m_axis_tvalid_o;
  logic       m_axis_tready_i = 1'b0;
  logic [7:0] m_axis_tdata_o;         // [6:0] out_char, [7] zero
  logic       m_axis_tlast_o;         // string_end

  typedef struct packed {
    logic [6:0] ch;
    logic       last;
  } text_char_t;

  // tracks the run being collected and the characters still owed by the block
  class string_tracker;
    logic [7:0]  run_buf [TEXT_MAX];
    int unsigned run_len;
    int unsigned alnum_cnt;
    int unsigned punct_cnt;
    bit          in_text;
    logic [5:0]  min_len;
    text_char_t  expected_chars[$];
    int unsigned errors;
    int unsigned chars_seen;
    int unsigned strings_seen;

    function new();
      run_len   = 0;
      alnum_cnt = 0;
      punct_cnt = 0;
      in_text   = 1'b0;
      min_len   = MIN_LENGTH_RESET;
      errors    = 0;
      chars_seen   = 0;
      strings_seen = 0;
    endfunction

    function void flag(string msg);
      errors++;
      $error("%s", msg);
    endfunction

    function bit letter_or_digit(logic [7:0] b);
      return (b >= 8'h30 && b <= 8'h39) || (b >= 8'h41 && b <= 8'h5A) ||
             (b >= 8'h61 && b <= 8'h7A);
    endfunction

    // punctuation minus the separators typical of protocol text
    function bit scored_punct(logic [7:0] b);
      bit any_punct;
      any_punct = (b >= 8'h21 && b <= 8'h2F) || (b >= 8'h3A && b <= 8'h40) ||
                  (b >= 8'h5B && b <= 8'h60) || (b >= 8'h7B && b <= 8'h7E);
      case (b)
        8'h2F, 8'h3D, 8'h5B, 8'h5D, 8'h5C, 8'h28, 8'h29,
        8'h7B, 8'h7D, 8'h3A, 8'h3C, 8'h3E, 8'h3B: return 1'b0;
        default: return any_punct;
      endcase
    endfunction

    // judge the run and queue its cleaned text when it qualifies
    function void close_run();
      int unsigned p;
      int unsigned n;
      logic [6:0]  c;
      logic [6:0]  prev;
      p = (punct_cnt == 0) ? 1 : punct_cnt;
      n = 0;
      prev = '0;
      if (run_len > min_len && alnum_cnt > p && (run_len / p) > 3) begin
        for (int k = 0; k < run_len; k++) begin
          c = run_buf[k][6:0];
          if (c < CHAR_SPACE || c == CHAR_DEL) c = CHAR_DOT;
          if (n > 0 && c == CHAR_DOT && prev == CHAR_DOT) continue;
          expected_chars.push_back('{ch: c, last: 1'b0});
          prev = c;
          n++;
        end
        if (n > 0) expected_chars[expected_chars.size() - 1].last = 1'b1;
      end
      run_len   = 0;
      alnum_cnt = 0;
      punct_cnt = 0;
      in_text   = 1'b0;
    endfunction

    function void note_word(logic [7:0] b, logic eob);
      bit run_byte;
      bit opener;
      run_byte = (b >= 8'h01 && b <= 8'h7E);
      opener   = (b >= 8'h20 && b <= 8'h7E);
      if (in_text && !run_byte) begin
        close_run();
      end else if (run_byte && (in_text || opener)) begin
        if (run_len < TEXT_MAX) begin
          run_buf[run_len] = b;
          run_len++;
          if (letter_or_digit(b)) alnum_cnt++;
          if (scored_punct(b)) punct_cnt++;
        end
        in_text = 1'b1;
        if (run_len >= TEXT_MAX || eob) close_run();
      end
    endfunction

    function void check_char(logic [6:0] ch, logic last);
      text_char_t want;
      if (expected_chars.size() == 0) begin
        flag($sformatf("character 0x%02h arrived with no string pending", ch));
        return;
      end
      want = expected_chars.pop_front();
      if (ch !== want.ch)
        flag($sformatf("out_char: expected 0x%02h, got 0x%02h", want.ch, ch));
      if (last !== want.last)
        flag($sformatf("string_end: expected %0b, got %0b", want.last, last));
      chars_seen++;
      if (want.last) strings_seen++;
    endfunction

    function int unsigned pending();
      return expected_chars.size();
    endfunction

    function void flag_leftovers();
      if (expected_chars.size() != 0)
        flag($sformatf("%0d characters never arrived", expected_chars.size()));
    endfunction
  endclass

  string_tracker sb;
  int unsigned   words_sent = 0;
  int unsigned   settings_used = 1;
  bit            tx_idle = 1'b0;
  bit            rx_idle = 1'b0;
  bit            long_hold_req = 1'b0;

  printable_string_extractor #(
    .MAX_RUN(TEXT_MAX)
  ) u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tlast_i (s_axis_tlast_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tlast_o (m_axis_tlast_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // mostly back to back, sometimes a short pause, rarely a long one
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [7:0] pick_text_char();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 25) return 8'(8'h61 + $urandom_range(0, 25));
    if (r < 40) return 8'(8'h41 + $urandom_range(0, 25));
    if (r < 52) return 8'(8'h30 + $urandom_range(0, 9));
    if (r < 64) return 8'(CHAR_SPACE);
    if (r < 80) return 8'($urandom_range(8'h21, 8'h7E));
    if (r < 92) return 8'($urandom_range(8'h01, 8'h1F));
    return 8'($urandom_range(8'h20, 8'h7E));
  endfunction

  function automatic logic [7:0] pick_stop_byte();
    if ($urandom_range(0, 9) < 3) return 8'h00;
    return 8'($urandom_range(8'h7F, 8'hFF));
  endfunction

  // receiver: random back-pressure plus one long hold on request
  initial begin : receiver
    int unsigned stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk_i);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        stall_left = LONG_HOLD;
      end else if (stall_left == 0 && rx_idle) begin
        stall_left = pick_gap();
      end
      if (stall_left > 0) begin
        m_axis_tready_i <= 1'b0;
        stall_left--;
      end else begin
        m_axis_tready_i <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i)
      sb.check_char(m_axis_tdata_o[6:0], m_axis_tlast_o);
  end

  task automatic send_word(input logic [7:0] b, input logic eob);
    int unsigned gap;
    gap = tx_idle ? pick_gap() : 0;
    if (gap > 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= b;
    s_axis_tlast_i  <= eob;
    do @(posedge clk_i); while (!s_axis_tready_o);
    sb.note_word(b, eob);
    words_sent++;
  endtask

  task automatic send_text(input string s, input logic eob_last);
    for (int i = 0; i < s.len(); i++)
      send_word(s[i], eob_last && (i == s.len() - 1));
  endtask

  // one text run with random content, then a stop byte, an end of buffer, or nothing
  task automatic send_random_run();
    int unsigned len;
    int unsigned ending;
    logic [7:0]  b;
    len    = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 70) : $urandom_range(1, 24);
    ending = $urandom_range(0, 9);
    for (int k = 0; k < len; k++) begin
      b = (k == 0) ? 8'($urandom_range(8'h20, 8'h7E)) : pick_text_char();
      send_word(b, ending >= 5 && ending <= 7 && k == len - 1);
    end
    if (ending < 5) send_word(pick_stop_byte(), $urandom_range(0, 7) == 0);
  endtask

  task automatic random_phase(input int unsigned n_words);
    int unsigned first;
    first = words_sent;
    while (words_sent - first < n_words) begin
      if ($urandom_range(0, 3) != 0) begin
        send_random_run();
      end else begin
        repeat ($urandom_range(1, 6))
          send_word(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
      end
    end
  endtask

  // wait for every owed character, then let a rejected run finish inside the block
  task automatic settle();
    s_axis_tvalid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_min_length(input logic [5:0] v);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.min_len = v;
    settings_used++;
  endtask

  initial begin : stimulus
    sb = new();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (3) @(posedge clk_i);

    // reset threshold, no idling on either side
    send_text("Hi, W0rld", 1'b0);
    send_word(8'h00, 1'b0);
    send_word(8'h05, 1'b0);
    send_word("a", 1'b0);
    send_word(8'h01, 1'b0);
    send_word(8'h02, 1'b0);
    send_word("b", 1'b0);
    send_word(8'h1F, 1'b0);
    send_text("cdef", 1'b0);
    send_word(8'h7E, 1'b1);
    send_word(8'hFF, 1'b1);
    send_word(8'h7F, 1'b0);
    send_text(" !?", 1'b0);
    send_word(8'h80, 1'b0);
    settle();

    // shortest threshold; the sink holds off for a long stretch early on
    set_min_length(6'd0);
    tx_idle = 1'b1;
    rx_idle = 1'b1;
    long_hold_req = 1'b1;
    random_phase(40);
    settle();

    // only a full buffer can qualify
    set_min_length(6'd63);
    tx_idle = 1'b0;
    for (int k = 0; k < TEXT_MAX; k++)
      send_word((k % 9 == 4) ? 8'h2D : 8'($urandom_range(8'h61, 8'h7A)), 1'b0);
    send_word(8'h03, 1'b0);
    send_text("tail", 1'b0);
    send_word(8'h00, 1'b0);
    tx_idle = 1'b1;
    random_phase(20);
    settle();

    set_min_length(6'd3);
    random_phase(30);
    settle();

    set_min_length(6'($urandom_range(1, 62)));
    random_phase(30);
    settle();

    set_min_length(MIN_LENGTH_RESET);
    rx_idle = 1'b0;
    random_phase(30);
    settle();

    sb.flag_leftovers();
    $display("covered %0d payload words under %0d min_length settings",
             words_sent, settings_used);
    $display("checked %0d characters in %0d extracted strings", sb.chars_seen,
             sb.strings_seen);
    if (sb.errors == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

  initial begin : watchdog
    #(TIMEOUT);
    $display("Mismatches found");
    $finish;
  end

endmodule
